FILE: rtl/bfc_pkg.sv
// Shared types and constants for the box frustum cull pipeline.
package bfc_pkg;

   localparam int COORD_BITS   = 24;
   localparam int COEF_BITS    = 20;
   localparam int ROW_BITS     = 3 * COEF_BITS;
   localparam int PROD_BITS    = COORD_BITS + COEF_BITS;
   localparam int CONST_SHIFT  = 8;
   localparam int CONST_BITS   = COEF_BITS + CONST_SHIFT;
   localparam int SUM_BITS     = PROD_BITS + 2;
   localparam int CMP_BITS     = SUM_BITS + 1;
   localparam int NUM_ROWS     = 4;
   localparam int NUM_CORNERS  = 4;
   localparam int NUM_PLANES   = 6;
   localparam int CSR_IDX_BITS = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COEF_BITS-1:0]  coef_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [CONST_BITS-1:0] const_type;
   typedef logic signed [SUM_BITS-1:0]   sum_type;
   typedef logic signed [CMP_BITS-1:0]   cmp_type;
   typedef logic [ROW_BITS-1:0]          row_type;
   typedef logic [CSR_IDX_BITS-1:0]      csr_idx_type;

   // register indexes, also the row order inside the pipeline
   localparam csr_idx_type REG_ROW_X = 3'd0;
   localparam csr_idx_type REG_ROW_Y = 3'd1;
   localparam csr_idx_type REG_ROW_Z = 3'd2;
   localparam csr_idx_type REG_ROW_W = 3'd3;

   localparam int ROW_W = 3;

   localparam row_type ROW_X_RESET = 60'd65536;
   localparam row_type ROW_Y_RESET = 60'd68719476736;
   localparam row_type ROW_Z_RESET = 60'd0;
   localparam row_type ROW_W_RESET = 60'd72057594037927936;

endpackage

FILE: rtl/box_frustum_cull_top.sv
// Box frustum cull: four-stage pipeline from box corners to a visibility flag.
// An accepted box passes the stage 1, 2 and 3 registers before the result register drives rsp_strobe.
// Throughput: one box per cycle while busy is low, set by the fully pipelined multiply, sum and compare stages.
// The result channel has no back pressure; busy is high only during and just after reset.
// Synchronous reset restores the row registers to identity-like defaults and empties the pipe.
module box_frustum_cull_top #(
   parameter int CHUNK_INDEX_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [CHUNK_INDEX_BITS-1:0]     req_chunk_index,
   input  logic                            req_box_valid,
   input  bfc_pkg::coord_type              req_min_x,
   input  bfc_pkg::coord_type              req_min_y,
   input  bfc_pkg::coord_type              req_max_x,
   input  bfc_pkg::coord_type              req_max_y,
   output logic                            rsp_strobe,
   output logic [CHUNK_INDEX_BITS-1:0]     rsp_chunk_id,
   output logic                            rsp_visible,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  bfc_pkg::csr_idx_type            csr_index,
   input  bfc_pkg::row_type                csr_data
);
   import bfc_pkg::*;

   logic    busy_ff;
   row_type row_ff [NUM_ROWS];

   // stage 1: products
   logic                        s1_valid_ff, s1_valid_in;
   logic [CHUNK_INDEX_BITS-1:0] s1_chunk_ff;
   logic                        s1_box_ff;
   prod_type                    s1_px_ff [NUM_ROWS][2];
   prod_type                    s1_py_ff [NUM_ROWS][2];
   const_type                   s1_c_ff  [NUM_ROWS];
   prod_type                    s1_px_in [NUM_ROWS][2];
   prod_type                    s1_py_in [NUM_ROWS][2];
   const_type                   s1_c_in  [NUM_ROWS];

   // stage 2: clip coordinates per corner
   logic                        s2_valid_ff;
   logic [CHUNK_INDEX_BITS-1:0] s2_chunk_ff;
   logic                        s2_box_ff;
   sum_type                     s2_clip_ff [NUM_ROWS][NUM_CORNERS];
   sum_type                     s2_clip_in [NUM_ROWS][NUM_CORNERS];

   // stage 3: plane flags
   logic                        s3_valid_ff;
   logic [CHUNK_INDEX_BITS-1:0] s3_chunk_ff;
   logic                        s3_box_ff;
   logic [NUM_CORNERS-1:0]      s3_out_ff [NUM_PLANES];
   logic [NUM_CORNERS-1:0]      s3_out_in [NUM_PLANES];

   // stage 4: result
   logic                        rsp_strobe_ff;
   logic [CHUNK_INDEX_BITS-1:0] rsp_chunk_ff;
   logic                        rsp_visible_ff, rsp_visible_in;

   assign busy        = busy_ff | reset;
   assign csr_ready   = ~reset;
   assign s1_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[REG_ROW_X[1:0]] <= ROW_X_RESET;
         row_ff[REG_ROW_Y[1:0]] <= ROW_Y_RESET;
         row_ff[REG_ROW_Z[1:0]] <= ROW_Z_RESET;
         row_ff[REG_ROW_W[1:0]] <= ROW_W_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ROW_X, REG_ROW_Y, REG_ROW_Z, REG_ROW_W: begin
               row_ff[csr_index[1:0]] <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         s1_px_in[r][0] = prod_type'(coef_type'(row_ff[r][COEF_BITS-1:0]))
                          * prod_type'(req_min_x);
         s1_px_in[r][1] = prod_type'(coef_type'(row_ff[r][COEF_BITS-1:0]))
                          * prod_type'(req_max_x);
         s1_py_in[r][0] = prod_type'(coef_type'(row_ff[r][2*COEF_BITS-1:COEF_BITS]))
                          * prod_type'(req_min_y);
         s1_py_in[r][1] = prod_type'(coef_type'(row_ff[r][2*COEF_BITS-1:COEF_BITS]))
                          * prod_type'(req_max_y);
         s1_c_in[r]     = {row_ff[r][3*COEF_BITS-1:2*COEF_BITS], {CONST_SHIFT{1'b0}}};
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_CORNERS; c++) begin
            s2_clip_in[r][c] = sum_type'(s1_px_ff[r][c % 2]) + sum_type'(s1_py_ff[r][c / 2])
                               + sum_type'(s1_c_ff[r]);
         end
      end
   end

   always_comb begin
      cmp_type w_val;
      cmp_type v_val;
      cmp_type lo_sum;
      cmp_type hi_dif;
      for (int p = 0; p < NUM_PLANES; p++) begin
         s3_out_in[p] = '0;
      end
      for (int c = 0; c < NUM_CORNERS; c++) begin
         w_val = cmp_type'(s2_clip_ff[ROW_W][c]);
         for (int r = 0; r < ROW_W; r++) begin
            v_val  = cmp_type'(s2_clip_ff[r][c]);
            lo_sum = v_val + w_val;
            hi_dif = w_val - v_val;
            s3_out_in[2*r][c]   = lo_sum[CMP_BITS-1];
            s3_out_in[2*r+1][c] = hi_dif[CMP_BITS-1];
         end
      end
   end

   always_comb begin
      rsp_visible_in = s3_box_ff;
      for (int p = 0; p < NUM_PLANES; p++) begin
         if (&s3_out_ff[p]) begin
            rsp_visible_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         rsp_strobe_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_chunk_ff    <= req_chunk_index;
      s1_box_ff      <= req_box_valid;
      s1_px_ff       <= s1_px_in;
      s1_py_ff       <= s1_py_in;
      s1_c_ff        <= s1_c_in;
      s2_chunk_ff    <= s1_chunk_ff;
      s2_box_ff      <= s1_box_ff;
      s2_clip_ff     <= s2_clip_in;
      s3_chunk_ff    <= s2_chunk_ff;
      s3_box_ff      <= s2_box_ff;
      s3_out_ff      <= s3_out_in;
      rsp_chunk_ff   <= s3_chunk_ff;
      rsp_visible_ff <= rsp_visible_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_chunk_id = rsp_chunk_ff;
   assign rsp_visible  = rsp_visible_ff;

endmodule
